[rtl/core/rbpi_pkg.sv]
// Rotated band pixel inverter: shared widths, reset values, register indexes
// and the payload types that move between the pipeline modules.
// No dependencies.
package rbpi_pkg;

  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned FracBits = 14;

  localparam int unsigned PixW     = $clog2(MaxDim);
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NlW      = 6;
  localparam int unsigned LwW      = 8;
  localparam int unsigned SinW     = 15;
  localparam int unsigned CosW     = 16;
  localparam int unsigned FdimW    = 13;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  localparam int unsigned PerW  = LwW + 1;
  localparam int unsigned SpanW = NlW + PerW;
  localparam int unsigned OffW  = FdimW + 2;
  localparam int unsigned ProdW = OffW + CosW;
  localparam int unsigned ShBase =
      (ProdW + 1 > SpanW + FracBits + 1) ? ProdW + 1 : SpanW + FracBits + 1;
  localparam int unsigned ShW   = ShBase + 2;
  localparam int unsigned PosW  = SpanW;
  localparam int unsigned QW    = NlW;

  localparam logic [NlW-1:0]   NumLinesRst    = NlW'(10);
  localparam logic [LwW-1:0]   LineWidthRst   = LwW'(8);
  localparam logic [LwW-1:0]   GapWidthRst    = LwW'(8);
  localparam logic [SinW-1:0]  SinCoefRst     = SinW'(0);
  localparam logic [CosW-1:0]  CosCoefRst     = CosW'(16384);
  localparam logic [FdimW-1:0] FrameWidthRst  = FdimW'(640);
  localparam logic [FdimW-1:0] FrameHeightRst = FdimW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    RegNumLines    = 3'd0,
    RegLineWidth   = 3'd1,
    RegGapWidth    = 3'd2,
    RegSinCoef     = 3'd3,
    RegCosCoef     = 3'd4,
    RegFrameWidth  = 3'd5,
    RegFrameHeight = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [NlW-1:0]          num_lines;
    logic [LwW-1:0]          line_width;
    logic [LwW-1:0]          gap_width;
    logic [SinW-1:0]         sin_coef;
    logic signed [CosW-1:0]  cos_coef;
    logic [FdimW-1:0]        frame_width;
    logic [FdimW-1:0]        frame_height;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic            valid;
    logic            region;
    logic [PosW-1:0] pos;
    rgb_t            rgb;
  } band_t;

endpackage

[rtl/core/rbpi_in_if.sv]
// Input pixel channel: valid/ready handshake with coordinates and color.
// Depends on rbpi_pkg.
interface rbpi_in_if;
  logic                         valid;
  logic                         ready;
  logic [rbpi_pkg::PixW-1:0]    pixel_x;
  logic [rbpi_pkg::PixW-1:0]    pixel_y;
  logic [rbpi_pkg::ChanW-1:0]   red_in;
  logic [rbpi_pkg::ChanW-1:0]   green_in;
  logic [rbpi_pkg::ChanW-1:0]   blue_in;

  modport source (output valid, pixel_x, pixel_y, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, pixel_x, pixel_y, red_in, green_in, blue_in, output ready);
endinterface

[rtl/core/rbpi_out_if.sv]
// Output pixel channel: valid/ready handshake with color and band flag.
// Depends on rbpi_pkg.
interface rbpi_out_if;
  logic                         valid;
  logic                         ready;
  logic [rbpi_pkg::ChanW-1:0]   red_out;
  logic [rbpi_pkg::ChanW-1:0]   green_out;
  logic [rbpi_pkg::ChanW-1:0]   blue_out;
  logic                         in_band;

  modport source (output valid, red_out, green_out, blue_out, in_band, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, in_band, output ready);
endinterface

[rtl/core/rotated_band_pixel_inverter_top.sv]
// Rotated band pixel inverter top level: configuration registers, pipeline
// control and the output register. Depends on rbpi_pkg, rbpi_in_if,
// rbpi_out_if, rbpi_proj and rbpi_mod.
//
// Usage:
//   in_i carries one pixel per transfer (column, row, three color bytes);
//   out_o returns one pixel per input in the same order, with each channel
//   inverted and in_band set when the pixel falls on a band.
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while no
//   pixel is in flight; unknown indexes are ignored.
//   The pipeline is 7 register stages from the input transfer to out_o.
//   Stages: three projection, three remainder (two quotient bits each, set
//   by the six-bit line count) and the output register.
//   Throughput is one pixel per cycle while no held result is stalled.
//   When out_o.ready is low while a result is held, every stage freezes and
//   in_i.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads the register defaults
//   (10 lines, width 8, gap 8, vertical axis, 640x480 frame).
module rotated_band_pixel_inverter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rbpi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rbpi_pkg::CfgDataW-1:0]  cfg_data_i,
  rbpi_in_if.sink                        in_i,
  rbpi_out_if.source                     out_o
);

  rbpi_pkg::cfg_t    cfg_q;
  rbpi_pkg::rgb_t    rgb_in;
  rbpi_pkg::band_t   band_proj, band_rem;
  logic [rbpi_pkg::PerW-1:0] period;
  logic              en;
  logic              hit;
  logic              out_valid_q, in_band_q;
  rbpi_pkg::rgb_t    rgb_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_lines    <= rbpi_pkg::NumLinesRst;
      cfg_q.line_width   <= rbpi_pkg::LineWidthRst;
      cfg_q.gap_width    <= rbpi_pkg::GapWidthRst;
      cfg_q.sin_coef     <= rbpi_pkg::SinCoefRst;
      cfg_q.cos_coef     <= rbpi_pkg::CosCoefRst;
      cfg_q.frame_width  <= rbpi_pkg::FrameWidthRst;
      cfg_q.frame_height <= rbpi_pkg::FrameHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbpi_pkg::RegNumLines:    cfg_q.num_lines    <= cfg_data_i[rbpi_pkg::NlW-1:0];
        rbpi_pkg::RegLineWidth:   cfg_q.line_width   <= cfg_data_i[rbpi_pkg::LwW-1:0];
        rbpi_pkg::RegGapWidth:    cfg_q.gap_width    <= cfg_data_i[rbpi_pkg::LwW-1:0];
        rbpi_pkg::RegSinCoef:     cfg_q.sin_coef     <= cfg_data_i[rbpi_pkg::SinW-1:0];
        rbpi_pkg::RegCosCoef:     cfg_q.cos_coef     <= cfg_data_i[rbpi_pkg::CosW-1:0];
        rbpi_pkg::RegFrameWidth:  cfg_q.frame_width  <= cfg_data_i[rbpi_pkg::FdimW-1:0];
        rbpi_pkg::RegFrameHeight: cfg_q.frame_height <= cfg_data_i[rbpi_pkg::FdimW-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a held result is stalled
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  assign rgb_in.red   = in_i.red_in;
  assign rgb_in.green = in_i.green_in;
  assign rgb_in.blue  = in_i.blue_in;

  assign period = rbpi_pkg::PerW'(cfg_q.line_width) + rbpi_pkg::PerW'(cfg_q.gap_width);

  rbpi_proj u_proj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_i.valid),
    .pixel_x_i (in_i.pixel_x),
    .pixel_y_i (in_i.pixel_y),
    .rgb_i     (rgb_in),
    .cfg_i     (cfg_q),
    .band_o    (band_proj)
  );

  rbpi_mod u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .period_i (period),
    .band_i   (band_proj),
    .band_o   (band_rem)
  );

  assign hit = band_rem.region && (band_rem.pos < rbpi_pkg::PosW'(cfg_q.line_width));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= band_rem.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_band_q <= hit;
      rgb_out_q <= hit ? ~band_rem.rgb : band_rem.rgb;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.red_out   = rgb_out_q.red;
  assign out_o.green_out = rgb_out_q.green;
  assign out_o.blue_out  = rgb_out_q.blue;
  assign out_o.in_band   = in_band_q;

endmodule

[rtl/core/rbpi_proj.sv]
// Projection pipeline: centre offsets, two coefficient products, then the
// span shift and band-region test. Three register stages. Depends on rbpi_pkg.
module rbpi_proj (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rbpi_pkg::PixW-1:0]  pixel_x_i,
  input  logic [rbpi_pkg::PixW-1:0]  pixel_y_i,
  input  rbpi_pkg::rgb_t             rgb_i,
  input  rbpi_pkg::cfg_t             cfg_i,
  output rbpi_pkg::band_t            band_o
);

  localparam int unsigned OffW  = rbpi_pkg::OffW;
  localparam int unsigned ProdW = rbpi_pkg::ProdW;
  localparam int unsigned SpanW = rbpi_pkg::SpanW;
  localparam int unsigned PerW  = rbpi_pkg::PerW;
  localparam int unsigned ShW   = rbpi_pkg::ShW;
  localparam int unsigned Frac  = rbpi_pkg::FracBits;

  // stage A: offsets at doubled scale, span
  logic signed [OffW-1:0]  dx2_d, dy2_d, dx2_q, dy2_q;
  logic [PerW-1:0]         period;
  logic [SpanW-1:0]        span_d, span_a_q, span_b_q;
  logic                    valid_a_q, valid_b_q;
  rbpi_pkg::rgb_t          rgb_a_q, rgb_b_q;

  // stage B: products
  logic signed [ProdW-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;

  // stage C: shift and range
  logic [ShW-1:0]          shifted;
  logic [ShW-1:0]          span_lo, span_hi;
  rbpi_pkg::band_t         band_d, band_q;

  assign period = PerW'(cfg_i.line_width) + PerW'(cfg_i.gap_width);
  assign span_d = SpanW'(cfg_i.num_lines) * SpanW'(period);
  assign dx2_d  = OffW'({pixel_x_i, 1'b0}) - OffW'(cfg_i.frame_width) + OffW'(1);
  assign dy2_d  = OffW'({pixel_y_i, 1'b0}) - OffW'(cfg_i.frame_height) + OffW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx2_q    <= dx2_d;
      dy2_q    <= dy2_d;
      span_a_q <= span_d;
      rgb_a_q  <= rgb_i;
    end
  end

  assign prod_x_d = dx2_q * $signed({1'b0, cfg_i.sin_coef});
  assign prod_y_d = dy2_q * $signed(cfg_i.cos_coef);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      span_b_q <= span_a_q;
      rgb_b_q  <= rgb_a_q;
    end
  end

  assign span_lo = ShW'({span_b_q, {Frac{1'b0}}});
  assign span_hi = ShW'({span_b_q, {(Frac + 1){1'b0}}});
  assign shifted = ShW'(prod_x_q) + ShW'(prod_y_q) + span_lo;

  always_comb begin
    band_d        = '0;
    band_d.valid  = valid_b_q;
    band_d.region = !shifted[ShW-1] && (shifted < span_hi);
    band_d.pos    = shifted[Frac+1 +: rbpi_pkg::PosW];
    band_d.rgb    = rgb_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= '0;
    end else if (en_i) begin
      band_q <= band_d;
    end
  end

  assign band_o = band_q;

endmodule

[rtl/core/rbpi_mod.sv]
// Pipelined restoring remainder: position modulo period, two quotient bits
// per register stage. Depends on rbpi_pkg.
module rbpi_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [rbpi_pkg::PerW-1:0]  period_i,
  input  rbpi_pkg::band_t            band_i,
  output rbpi_pkg::band_t            band_o
);

  localparam int unsigned QW           = rbpi_pkg::QW;
  localparam int unsigned RemW         = rbpi_pkg::PosW;
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned Stages       = (QW + BitsPerStage - 1) / BitsPerStage;

  rbpi_pkg::band_t stg_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    rbpi_pkg::band_t cur;
    rbpi_pkg::band_t nxt;
    logic [RemW-1:0] dvs;

    if (s == 0) begin : g_head
      assign cur = band_i;
    end else begin : g_tail
      assign cur = stg_q[s-1];
    end

    always_comb begin
      nxt = cur;
      dvs = '0;
      for (int j = 0; j < BitsPerStage; j++) begin
        if (s * BitsPerStage + j < QW) begin
          dvs = RemW'(period_i) << (QW - 1 - s * BitsPerStage - j);
          if (nxt.pos >= dvs) begin
            nxt.pos = nxt.pos - dvs;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q[s] <= '0;
      end else if (en_i) begin
        stg_q[s] <= nxt;
      end
    end
  end

  assign band_o = stg_q[Stages-1];

endmodule
